// ----- sv/cla_pkg.sv -----
// Shared types and constants for the CR/LF line assembler.
// No dependencies; imported by cla_cmd_fifo, cla_front, cla_back and the top level.
package cla_pkg;

	localparam int MAX_LINE    = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int RAM_DEPTH   = 2 * STORE_DEPTH;          // two banks, one per line in flight
	localparam int RAM_AW      = $clog2(RAM_DEPTH);
	localparam int FILL_W      = $clog2(MAX_LINE);          // holds 0 .. MAX_LINE-1
	localparam int COUNT_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);
	localparam int LINES_MAX   = 2;                         // lines pushed but not yet sent
	localparam int LINES_W     = $clog2(LINES_MAX + 1);
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 48;

	localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(MAX_LINE - 1);

	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

	localparam logic ACT_BYTE       = 1'b0;
	localparam logic ACT_LINE_STATE = 1'b1;
	localparam logic KIND_CHAR      = 1'b0;
	localparam logic KIND_STATUS    = 1'b1;

	// work handed from front to back
	typedef struct packed {
		logic               is_status;
		logic               bank;
		logic [FILL_W-1:0]  len;
		logic               connected;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	// back end status toward the front
	typedef struct packed {
		logic line_done;
	} back_stat_t;

endpackage

// ----- sv/cla_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/cla_cmd_fifo.sv -----
// Short command queue between front end and back end.
// Depends on cla_pkg.
module cla_cmd_fifo
	import cla_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output cmd_t head,
	output logic full
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("command queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMDQ_CW'(CMDQ_DEPTH))
		else $error("command queue count out of range");

endmodule

// ----- sv/cla_front.sv -----
// Front end: accepts input words, tracks fill position, link flag and change
// counter, writes line bytes to the store and queues commands. Depends on cla_pkg.
module cla_front
	import cla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd,
	output logic                 ram_we,
	output logic [RAM_AW-1:0]    ram_waddr,
	output logic [CHAR_W-1:0]    ram_wdata,
	input  back_stat_t           back_stat
);

	logic [FILL_W-1:0]  fill_q;
	logic               bank_q;
	logic               link_q;
	logic [COUNT_W-1:0] count_q;
	logic [LINES_W-1:0] lines_q;

	logic               accept;
	logic               action;
	logic [CHAR_W-1:0]  rx_byte;
	logic               dtr;
	logic               is_term;
	logic               push_line;
	logic [COUNT_W-1:0] count_next;

	assign action  = s_axis_tuser;
	assign rx_byte = s_axis_tdata[CHAR_W-1:0];
	assign dtr     = s_axis_tdata[CHAR_W];
	assign is_term = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	// the bank being filled must not hold a line still being sent
	assign s_axis_tready = !q_full && (lines_q < LINES_W'(LINES_MAX));
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign count_next = (link_q != dtr) ? count_q + 1'b1 : count_q;
	assign push_line  = accept && (action == ACT_BYTE) && is_term && (fill_q != '0);
	assign push       = push_line || (accept && (action == ACT_LINE_STATE));

	always_comb begin
		push_cmd.is_status = (action == ACT_LINE_STATE);
		push_cmd.bank      = bank_q;
		push_cmd.len       = fill_q;
		if (action == ACT_LINE_STATE) begin
			push_cmd.connected = dtr;
			push_cmd.count     = count_next;
		end else begin
			push_cmd.connected = link_q;
			push_cmd.count     = count_q;
		end
	end

	assign ram_we    = accept && (action == ACT_BYTE) && !is_term && (fill_q < FILL_LIMIT);
	assign ram_waddr = {bank_q, ADDR_W'(fill_q)};
	assign ram_wdata = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bank_q  <= 1'b0;
			link_q  <= 1'b0;
			count_q <= '0;
			lines_q <= '0;
		end else begin
			if (accept) begin
				if (action == ACT_LINE_STATE) begin
					link_q  <= dtr;
					count_q <= count_next;
					if (link_q && !dtr) begin
						fill_q <= '0;   // disconnect drops the partial line
					end
				end else if (is_term) begin
					fill_q <= '0;
					if (fill_q != '0) begin
						bank_q <= !bank_q;
					end
				end else if (fill_q < FILL_LIMIT) begin
					fill_q <= fill_q + 1'b1;
				end else begin
					fill_q <= '0;       // overflow discards the line
				end
			end
			if (push_line && !back_stat.line_done) begin
				lines_q <= lines_q + 1'b1;
			end else if (!push_line && back_stat.line_done) begin
				lines_q <= lines_q - 1'b1;
			end
		end
	end

	a_lines_range: assert property (@(posedge clk) disable iff (!arst_n)
		lines_q <= LINES_W'(LINES_MAX))
		else $error("too many lines in flight");

	a_done_has_line: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.line_done |-> (lines_q != '0))
		else $error("line completion without an outstanding line");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (fill_q < FILL_LIMIT))
		else $error("store write beyond line limit");

endmodule

// ----- sv/cla_back.sv -----
// Back end: takes commands from the queue, reads stored lines one byte at a
// time and drives the output register. Depends on cla_pkg.
module cla_back
	import cla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 pop,
	output logic                 ram_re,
	output logic [RAM_AW-1:0]    ram_raddr,
	input  logic [CHAR_W-1:0]    ram_rdata,
	output back_stat_t           back_stat,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t             state_q;
	logic               bank_q;
	logic [FILL_W-1:0]  len_q;
	logic [FILL_W-1:0]  idx_q;
	logic               conn_q;
	logic [COUNT_W-1:0] cnt_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic               out_conn_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic can_load;
	logic load_status;
	logic load_char;
	logic last_char;

	assign can_load    = !out_valid_q || m_axis_tready;
	assign load_status = (state_q == ST_IDLE) && cmd_valid && cmd.is_status && can_load;
	assign pop         = (state_q == ST_IDLE) && cmd_valid && (!cmd.is_status || can_load);
	assign load_char   = (state_q == ST_LOAD) && can_load;
	assign last_char   = (idx_q == len_q - 1'b1);

	assign ram_re    = (state_q == ST_READ);
	assign ram_raddr = {bank_q, ADDR_W'(idx_q)};

	assign back_stat.line_done = load_char && last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && !cmd.is_status) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load_char) begin
						state_q <= last_char ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_status || load_char) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.is_status) begin
			bank_q <= cmd.bank;
			len_q  <= cmd.len;
			conn_q <= cmd.connected;
			cnt_q  <= cmd.count;
			idx_q  <= '0;
		end else if (load_char) begin
			idx_q <= idx_q + 1'b1;
		end
		if (load_status) begin
			out_kind_q <= KIND_STATUS;
			out_char_q <= '0;
			out_last_q <= 1'b1;
			out_conn_q <= cmd.connected;
			out_cnt_q  <= cmd.count;
		end else if (load_char) begin
			out_kind_q <= KIND_CHAR;
			out_char_q <= ram_rdata;
			out_last_q <= last_char;
			out_conn_q <= conn_q;
			out_cnt_q  <= cnt_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(M_TDATA_W - CHAR_W - 1 - COUNT_W){1'b0}},
		out_cnt_q, out_conn_q, out_char_q};

	a_read_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (idx_q < len_q))
		else $error("store read past end of line");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.line_done |=> (state_q == ST_IDLE))
		else $error("line finished but sequencer not idle");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> ($stable(out_char_q) && $stable(out_cnt_q)))
		else $error("output register overwritten while stalled");

endmodule

// ----- sv/crlf_line_assembler.sv -----
// CR/LF line assembler: collects received bytes into lines and reports
// line-state events. Input words on s_axis: tuser = action (0 byte, 1 line
// state), tdata = rx_byte and dtr. Results on m_axis: tuser = kind (0 line
// character, 1 status), tlast = last character of a line (always 1 for a
// status word), tdata = line_char, connected, change_count.
// A byte is stored and emits nothing; CR or LF releases the stored line,
// empty lines emit nothing. The back end reads each character from the
// store and loads it into the output register before reading the next;
// a status word passes through the command queue and the output
// register. The store holds two banks, so one line can be sent while the
// next fills; input stalls when both banks hold unsent lines or the
// command queue is full. Reset clears fill position, link flag, change
// counter and all queues; store contents need no clearing. When m_axis
// stalls the output register holds its word, the back end waits, and the
// front keeps taking bytes until the queue or banks fill up.
// Depends on cla_pkg, cla_front, cla_cmd_fifo, cla_ram, cla_back.
module crlf_line_assembler
	import cla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte, [8] dtr, [15:9] zero
	input  logic                 s_axis_tuser,  // [0] action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // [7:0] line_char, [8] connected,
	                                            // [40:9] change_count, [47:41] zero
	output logic                 m_axis_tuser,  // [0] kind
	output logic                 m_axis_tlast
);

	logic              q_full;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	logic              cmd_valid;
	cmd_t              head;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;
	back_stat_t        back_stat;

	cla_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.back_stat     (back_stat)
	);

	cla_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.valid    (cmd_valid),
		.head     (head),
		.full     (q_full)
	);

	cla_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cla_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (head),
		.pop           (pop),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.back_stat     (back_stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- sim/tb_crlf_line_assembler.sv -----
// Testbench for crlf_line_assembler: queued stimulus words, a line predictor,
// and an in-order check of every m_axis word. Depends on cla_pkg and the RTL.
module tb_crlf_line_assembler
	import cla_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 410;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CALM_FIRST     = 150;
	localparam int CALM_LAST      = 230;

	typedef struct {
		logic             action;
		logic [CHAR_W-1:0] rx;
		logic             dtr;
		logic             hold;   // wait for all results before sending
		logic             calm;   // no idling on either side
	} rx_item_t;

	typedef struct packed {
		logic               kind;
		logic [CHAR_W-1:0]  ch;
		logic               last;
		logic               conn;
		logic [COUNT_W-1:0] count;
	} line_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	rx_item_t   rx_items[$];
	line_word_t pending_words[$];
	logic       calm = 1'b0;
	logic       hold_next = 1'b0;
	logic       failed = 1'b0;
	int         queued = 0;
	int         quiet_cycles = 0;

	// predictor state
	logic [CHAR_W-1:0]  line_buf [STORE_DEPTH];
	int                 fill_pos = 0;
	logic               link = 1'b0;
	logic [COUNT_W-1:0] toggles = '0;

	crlf_line_assembler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_item(logic action, logic [CHAR_W-1:0] rx, logic dtr);
		rx_item_t it;
		it.action = action;
		it.rx     = rx;
		it.dtr    = dtr;
		it.hold   = hold_next;
		it.calm   = (queued >= CALM_FIRST && queued < CALM_LAST);
		hold_next = 1'b0;
		rx_items.push_back(it);
		queued++;
	endfunction

	function automatic void push_byte(logic [CHAR_W-1:0] b);
		push_item(ACT_BYTE, b, 1'($urandom_range(1)));
	endfunction

	function automatic void push_event(logic dtr);
		push_item(ACT_LINE_STATE, 8'($urandom_range(255)), dtr);
	endfunction

	function automatic logic [CHAR_W-1:0] text_byte();
		logic [CHAR_W-1:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	// advance the line state by one accepted word and queue the words it releases
	function automatic void assemble_step(logic action, logic [CHAR_W-1:0] rx, logic dtr);
		line_word_t w;
		if (action == ACT_LINE_STATE) begin
			if (link != dtr) begin
				toggles++;
				if (!dtr)
					fill_pos = 0;
			end
			link = dtr;
			w = '{kind: KIND_STATUS, ch: '0, last: 1'b1, conn: link, count: toggles};
			pending_words.push_back(w);
		end else if (rx == CH_CR || rx == CH_LF) begin
			for (int k = 0; k < fill_pos; k++) begin
				w = '{kind: KIND_CHAR, ch: line_buf[k], last: (k == fill_pos - 1),
				      conn: link, count: toggles};
				pending_words.push_back(w);
			end
			fill_pos = 0;
		end else if (fill_pos < MAX_LINE - 1) begin
			line_buf[fill_pos] = rx;
			fill_pos++;
		end else begin
			// full store: byte dropped, partial line discarded
			fill_pos = 0;
		end
	endfunction

	task automatic check_field(string tag, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
			failed = 1'b1;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : drive_proc
		rx_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			calm          <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (rx_items.size() != 0
			    && !(rx_items[0].hold && (s_axis_tvalid || pending_words.size() != 0))
			    && (rx_items[0].calm || $urandom_range(99) >= 21)) begin
				it = rx_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= it.action;
				s_axis_tdata  <= {7'b0, it.dtr, it.rx};
				calm          <= it.calm;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 21);
		end
	end

	// prediction, checking and watchdog
	always @(posedge clk) begin : watch_proc
		line_word_t want;
		line_word_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				assemble_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{kind: m_axis_tuser, ch: m_axis_tdata[7:0], last: m_axis_tlast,
				        conn: m_axis_tdata[8], count: m_axis_tdata[40:9]};
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h", $time, got);
					failed = 1'b1;
				end else begin
					want = pending_words.pop_front();
					check_field("kind", COUNT_W'(want.kind), COUNT_W'(got.kind));
					check_field("line_char", COUNT_W'(want.ch), COUNT_W'(got.ch));
					check_field("is_last", COUNT_W'(want.last), COUNT_W'(got.last));
					check_field("connected", COUNT_W'(want.conn), COUNT_W'(got.conn));
					check_field("change_count", want.count, got.count);
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("tb_crlf_line_assembler: FAIL");
				$finish;
			end
		end
	end

	initial begin : stim_proc
		int r;
		int len;
		int term;
		// directed: extremes, terminators, empty lines and every link transition
		push_event(1'b1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h41);
		push_byte(CH_CR);
		push_byte(CH_LF);          // CR then LF: second sees empty store
		push_byte(CH_LF);          // empty line
		push_event(1'b1);          // same level
		push_byte(8'h7F);
		push_byte(8'h80);
		push_event(1'b0);          // disconnect drops the partial line
		push_byte(CH_CR);
		push_event(1'b0);
		push_byte(8'h55);
		push_event(1'b1);          // connect keeps the partial line
		push_byte(8'hAA);
		push_byte(CH_LF);
		push_byte(8'h09);
		push_byte(8'h0B);
		push_byte(8'h0C);
		push_byte(8'h0E);
		push_byte(CH_CR);

		hold_next = 1'b1;
		while (queued < ITEM_TARGET) begin
			if ($urandom_range(99) < 3)
				hold_next = 1'b1;
			r = $urandom_range(99);
			if (r < 70) begin
				r = $urandom_range(99);
				if (r < 4)
					len = MAX_LINE - 1;
				else if (r < 7)
					len = $urandom_range(MAX_LINE, MAX_LINE + 6);   // overflow
				else if (r < 9)
					len = MAX_LINE - 2;
				else
					len = $urandom_range(12);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(99) < 3)
						push_event(1'($urandom_range(1)));
					push_byte(text_byte());
				end
				term = $urandom_range(2);
				if (term == 0) begin
					push_byte(CH_CR);
				end else if (term == 1) begin
					push_byte(CH_LF);
				end else begin
					push_byte(CH_CR);
					push_byte(CH_LF);
				end
			end else if (r < 85) begin
				push_event(1'($urandom_range(1)));
			end else begin
				push_byte(8'($urandom_range(255)));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_items.size() != 0 || s_axis_tvalid || pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("tb_crlf_line_assembler: PASS");
		else
			$display("tb_crlf_line_assembler: FAIL");
		$finish;
	end

endmodule
